@@ src/tdsa_pkg.sv @@
package tdsa_pkg;

    // width of the magnitude fed to the divider and of the signed working value
    localparam int DIV_W      = 17;
    localparam int ACC_W      = DIV_W + 1;
    localparam int BASE_W     = 10;
    // reciprocal scale: any base up to 1000 gives exact quotients below 2**DIV_W
    localparam int RECIP_SHIFT = DIV_W + BASE_W;
    localparam int RECIP_W     = RECIP_SHIFT;

    localparam logic [BASE_W-1:0] MILLI_BASE  = 10'd1000;
    localparam logic [BASE_W-1:0] SECOND_BASE = 10'd60;
    localparam logic [BASE_W-1:0] MINUTE_BASE = 10'd60;

    // reciprocals rounded up
    localparam logic [RECIP_W-1:0] MILLI_RECIP  =
        RECIP_W'((1 << RECIP_SHIFT) / int'(MILLI_BASE) + 1);
    localparam logic [RECIP_W-1:0] SECOND_RECIP =
        RECIP_W'((1 << RECIP_SHIFT) / int'(SECOND_BASE) + 1);
    localparam logic [RECIP_W-1:0] MINUTE_RECIP =
        RECIP_W'((1 << RECIP_SHIFT) / int'(MINUTE_BASE) + 1);

    typedef enum logic [1:0] {
        UNIT_MILLI  = 2'd0,
        UNIT_SECOND = 2'd1,
        UNIT_MINUTE = 2'd2,
        UNIT_HOUR   = 2'd3
    } t_unit;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [BASE_W-1:0]  divisor;
        logic [RECIP_W-1:0] recip;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quo;
        logic [BASE_W-1:0] rem;
    } t_div_rsp;

endpackage

@@ src/tdsa_if.sv @@
interface tdsa_cmd_if import tdsa_pkg::*;;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [15:0] amount;

    modport source (output valid, output cmd, output amount, input ready);
    modport sink   (input valid, input cmd, input amount, output ready);
endinterface

interface tdsa_time_if import tdsa_pkg::*;;
    logic       valid;
    logic       ready;
    logic [4:0] hour_now;
    logic [5:0] minute_now;
    logic [5:0] second_now;
    logic [9:0] milli_now;

    modport source (output valid, output hour_now, output minute_now, output second_now,
                    output milli_now, input ready);
    modport sink   (input valid, input hour_now, input minute_now, input second_now,
                    input milli_now, output ready);
endinterface

@@ src/tdsa_div.sv @@
module tdsa_div import tdsa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int PROD_W = DIV_W + RECIP_W;
    localparam int BACK_W = DIV_W + BASE_W;

    logic [DIV_W-1:0]   r_num;
    logic [RECIP_W-1:0] r_recip;
    logic [BASE_W-1:0]  r_div;
    logic [DIV_W-1:0]   r_quo;
    logic [BASE_W-1:0]  r_rem;
    logic               r_quo_step;
    logic               r_rem_step;
    logic               r_done;

    logic [PROD_W-1:0]  w_prod;
    logic [BACK_W-1:0]  w_back;
    logic [DIV_W-1:0]   w_rem_full;

    // quotient from the rounded-up reciprocal, remainder from the registered quotient in the next cycle
    assign w_prod     = PROD_W'(r_num) * PROD_W'(r_recip);
    assign w_back     = BACK_W'(r_quo) * BACK_W'(r_div);
    assign w_rem_full = r_num - w_back[DIV_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quo_step <= 1'b0;
            r_rem_step <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_quo_step <= i_req.start;
            r_rem_step <= r_quo_step;
            r_done     <= r_rem_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num   <= i_req.dividend;
            r_recip <= i_req.recip;
            r_div   <= i_req.divisor;
        end
        if (r_quo_step) begin
            r_quo <= w_prod[RECIP_SHIFT +: DIV_W];
        end
        if (r_rem_step) begin
            r_rem <= w_rem_full[BASE_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

    a_done_after_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_rem_step))
        else $error("divider done without a remainder step");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_quo_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ((w_back[BACK_W-1:DIV_W] == '0)
                    && (w_back[DIV_W-1:0] + DIV_W'(r_rem) == r_num)))
        else $error("divider quotient and remainder do not rebuild the dividend");

endmodule

@@ src/time_of_day_signed_adder.sv @@
// sequence: each unit visited takes a load, quotient, remainder and write-back step, one to four
// units, then a hand-over step moves the result to the output register once it is free
// one transaction at a time through the shared divider; the next command is taken
// as soon as the result is in the output register
// reset: synchronous active low, clears the working time to 00:00:00.000 and drops the output valid
module time_of_day_signed_adder import tdsa_pkg::*; #(
    parameter int HOURS_PER_DAY = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tdsa_cmd_if.sink    i_cmd,
    tdsa_time_if.source o_time
);

    localparam logic [BASE_W-1:0] HourBase = BASE_W'(HOURS_PER_DAY);
    localparam logic [RECIP_W-1:0] HourRecip = RECIP_W'((1 << RECIP_SHIFT) / HOURS_PER_DAY + 1);

    t_state                r_state;
    t_unit                 r_unit;
    logic signed [ACC_W-1:0] r_carry;
    logic                  r_neg;
    logic [4:0]            r_hour;
    logic [5:0]            r_minute;
    logic [5:0]            r_second;
    logic [9:0]            r_milli;
    logic                  r_ovalid;
    logic [4:0]            r_o_hour;
    logic [5:0]            r_o_minute;
    logic [5:0]            r_o_second;
    logic [9:0]            r_o_milli;

    logic signed [ACC_W-1:0] w_field;
    logic signed [ACC_W-1:0] w_sum;
    logic [ACC_W-1:0]      w_abs;
    logic [BASE_W-1:0]     w_base;
    logic [RECIP_W-1:0]    w_recip;
    logic                  w_rem_zero;
    logic [BASE_W-1:0]     w_rem;
    logic signed [ACC_W-1:0] w_quo;
    logic signed [ACC_W-1:0] n_carry;
    logic                  w_last;
    logic                  w_out_free;
    t_div_req              w_req;
    t_div_rsp              w_rsp;

    always_comb begin
        unique case (r_unit)
            UNIT_MILLI: begin
                w_field = ACC_W'(r_milli);
                w_base  = MILLI_BASE;
                w_recip = MILLI_RECIP;
            end
            UNIT_SECOND: begin
                w_field = ACC_W'(r_second);
                w_base  = SECOND_BASE;
                w_recip = SECOND_RECIP;
            end
            UNIT_MINUTE: begin
                w_field = ACC_W'(r_minute);
                w_base  = MINUTE_BASE;
                w_recip = MINUTE_RECIP;
            end
            default: begin
                w_field = ACC_W'(r_hour);
                w_base  = HourBase;
                w_recip = HourRecip;
            end
        endcase
    end

    assign w_sum = w_field + r_carry;
    assign w_abs = w_sum[ACC_W-1] ? ACC_W'(-w_sum) : ACC_W'(w_sum);

    assign w_req.start    = (r_state == S_LOAD);
    assign w_req.dividend = w_abs[DIV_W-1:0];
    assign w_req.divisor  = w_base;
    assign w_req.recip    = w_recip;

    tdsa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // floor division: a negative value with a remainder borrows one more
    assign w_rem_zero = (w_rsp.rem == '0);
    assign w_quo      = ACC_W'(w_rsp.quo);
    always_comb begin
        if (r_neg && !w_rem_zero) begin
            w_rem   = w_base - w_rsp.rem;
            n_carry = -(w_quo + ACC_W'(1));
        end else if (r_neg) begin
            w_rem   = w_rsp.rem;
            n_carry = -w_quo;
        end else begin
            w_rem   = w_rsp.rem;
            n_carry = w_quo;
        end
    end

    assign w_last     = (r_unit == UNIT_HOUR) || (n_carry == '0);
    assign w_out_free = !r_ovalid || o_time.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_unit   <= UNIT_MILLI;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
            r_milli  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_time.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_unit  <= t_unit'(i_cmd.cmd);
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_rsp.done) begin
                        unique case (r_unit)
                            UNIT_MILLI:  r_milli  <= w_rem;
                            UNIT_SECOND: r_second <= w_rem[5:0];
                            UNIT_MINUTE: r_minute <= w_rem[5:0];
                            default:     r_hour   <= w_rem[4:0];
                        endcase
                        if (w_last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_unit  <= t_unit'(r_unit + 2'd1);
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // working registers without reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd.valid) begin
            r_carry <= ACC_W'(i_cmd.amount);
        end else if (r_state == S_DIV && w_rsp.done) begin
            r_carry <= n_carry;
        end
        if (r_state == S_LOAD) begin
            r_neg <= w_sum[ACC_W-1];
        end
        if (r_state == S_DONE && w_out_free) begin
            r_o_hour   <= r_hour;
            r_o_minute <= r_minute;
            r_o_second <= r_second;
            r_o_milli  <= r_milli;
        end
    end

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_time.valid      = r_ovalid;
    assign o_time.hour_now   = r_o_hour;
    assign o_time.minute_now = r_o_minute;
    assign o_time.second_now = r_o_second;
    assign o_time.milli_now  = r_o_milli;

    a_accept_starts_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> (r_state == S_LOAD))
        else $error("accepted transaction did not start a pass");

    a_milli_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_milli < 10'd1000)
        else $error("millisecond count out of range");

    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hour < HourBase[4:0] || HOURS_PER_DAY > 31)
        else $error("hour count out of range");

    a_minsec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_minute < 6'd60) && (r_second < 6'd60))
        else $error("minute or second count out of range");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside a division step");

endmodule
